/* rtl/core/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg: shared definitions for the LRU block cache manager
// Sizes, operation and result codes, the recency cell entry used by the
// cell chain and the controller states used by the top level.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int FRAMES_MAX = 8;
  localparam int BLOCKS_MAX = 1024;
  localparam int FRAME_W    = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;
  localparam int BLK_W      = $clog2(BLOCKS_MAX);
  localparam int COUNT_W    = $clog2(FRAMES_MAX + 1);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  localparam logic [1:0] FILL_NONE = 2'd0;
  localparam logic [1:0] FILL_LOAD = 2'd1;
  localparam logic [1:0] FILL_ZERO = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_UNALLOC = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  localparam logic REG_BLOCK_LOG2 = 1'b0;
  localparam logic REG_MAX_RES    = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [BLK_W-1:0]   blk;
    logic [FRAME_W-1:0] frame;
    logic               dirty;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC_CHK,
    S_ALLOC_RUN,
    S_ACCESS
  } state_t;

  // Block size exponent, clamped to the supported range.
  function automatic logic [4:0] eff_log2(input logic [4:0] v);
    if (v < 5'd4) begin
      return 5'd4;
    end else if (v > 5'd16) begin
      return 5'd16;
    end
    return v;
  endfunction

  // Resident limit, clamped to one frame up to the whole pool.
  function automatic logic [COUNT_W-1:0] eff_max(input logic [3:0] v);
    if (v == 4'd0) begin
      return COUNT_W'(1);
    end else if (32'(v) > FRAMES_MAX) begin
      return COUNT_W'(FRAMES_MAX);
    end
    return COUNT_W'(v);
  endfunction

endpackage

/* rtl/core/lbc_cell.sv */
// ----------------------------------------------------------------------------
// lbc_cell: one place of the recency list
// Holds one resident block and takes its neighbour's entry when told to shift.
// ----------------------------------------------------------------------------
module lbc_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  lbc_pkg::entry_t            prev,
  input  logic [lbc_pkg::BLK_W-1:0]  key,
  output lbc_pkg::entry_t            entry,
  output logic                       match
);
  import lbc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (shift) begin
      entry <= prev;
    end
  end

  assign match = entry.valid && (entry.blk == key);

endmodule

/* rtl/core/lru_block_cache_manager_unit.sv */
// ----------------------------------------------------------------------------
// lru_block_cache_manager_unit: LRU frame manager for a growing block heap
// Tracks heap growth in blocks and keeps the resident blocks in a chain of
// recency cells, most recent in cell 0, reporting write-back and fill work.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Transfer rule
//  --------  ----------------------------------------  ------------------------
//  command   start, busy, opcode, byte_count,          start high, busy low
//            block_index
//  result    done, alloc_offset, frame, hit,           done high for one cycle
//            writeback_valid, writeback_block,
//            fill_action, status
//  config    cfg_wr_en, cfg_index, cfg_data            cfg_wr_en high
//
// An access transaction reads the fresh-block memory on acceptance, then
// searches the cell chain and shifts it in S_ACCESS. An alloc transaction
// checks for room in S_ALLOC_CHK and, if there is room, creates its blocks
// in S_ALLOC_RUN, one block per cycle through the single memory write port.
// An unused opcode answers in the next cycle. Reset clears the counters and
// the chain at once; the fresh-block memory needs no clearing, since only
// entries of created blocks are ever used. The result port cannot be stalled.
module lru_block_cache_manager_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [19:0]                   byte_count,
  input  logic [lbc_pkg::BLK_W-1:0]     block_index,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [4:0]                    cfg_data,
  output logic                          done,
  output logic [25:0]                   alloc_offset,
  output logic [lbc_pkg::FRAME_W-1:0]   frame,
  output logic                          hit,
  output logic                          writeback_valid,
  output logic [lbc_pkg::BLK_W-1:0]     writeback_block,
  output logic [1:0]                    fill_action,
  output logic [1:0]                    status
);
  import lbc_pkg::*;

  // Configuration registers.
  logic [4:0] log2_reg;
  logic [3:0] max_res_reg;

  // Controller state and the latched transaction.
  state_t             state;
  state_t             state_next;
  opcode_t            op_r;
  logic [19:0]        cnt_r;
  logic [BLK_W-1:0]   idx_r;
  logic [BLK_W-1:0]   endblk_r;
  logic [26:0]        bytes_used;
  logic [BLK_W:0]     blocks_created;
  logic [COUNT_W-1:0] count;

  // Fresh flag per block: set while a block has never been brought into a
  // frame, so that its first use is a zero fill rather than a load.
  logic               fresh_mem [BLOCKS_MAX];
  logic               fresh_q;
  logic               mem_we;
  logic [BLK_W-1:0]   mem_waddr;
  logic               mem_wdata;

  // Recency chain.
  entry_t             cells [FRAMES_MAX];
  entry_t             prev  [FRAMES_MAX];
  logic [FRAMES_MAX-1:0] match;
  logic [FRAMES_MAX-1:0] shift;
  entry_t             front;
  entry_t             hit_entry;
  entry_t             victim;
  logic [COUNT_W-1:0] count_m1;
  logic               hit_any;

  // Datapath terms.
  logic [27:0]        newused;
  logic [26:0]        endblk_w;
  logic               table_full;
  logic               create_more;
  logic               give_frame;
  logic               unalloc;
  logic               is_write;
  logic               accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  for (genvar g = 0; g < FRAMES_MAX; g++) begin : g_chain
    if (g == 0) begin : g_head
      assign prev[g] = front;
    end else begin : g_body
      assign prev[g] = cells[g-1];
    end
    lbc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift[g]),
      .prev  (prev[g]),
      .key   (idx_r),
      .entry (cells[g]),
      .match (match[g])
    );
  end

  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < FRAMES_MAX; i++) begin
      if (match[i]) begin
        hit_entry = hit_entry | cells[i];
      end
    end
  end

  assign hit_any  = |match;
  assign count_m1 = count - COUNT_W'(1);
  assign victim   = cells[count_m1[FRAME_W-1:0]];
  assign is_write = (op_r == OP_WRITE);

  assign newused     = {1'b0, bytes_used} + {8'b0, cnt_r};
  assign endblk_w    = newused[26:0] >> eff_log2(log2_reg);
  assign table_full  = newused[27] || (endblk_w >= 27'(BLOCKS_MAX));
  assign create_more = (blocks_created <= {1'b0, endblk_r});
  assign give_frame  = (blocks_created < (BLK_W+1)'(eff_max(max_res_reg)))
                       && (count < COUNT_W'(FRAMES_MAX));
  assign unalloc     = ({1'b0, idx_r} >= blocks_created);

  // Next state, chain shifting and memory writes.
  always_comb begin
    state_next = state;
    shift      = '0;
    front      = '0;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (opcode_t'(opcode))
            OP_ALLOC:          state_next = S_ALLOC_CHK;
            OP_READ, OP_WRITE: state_next = S_ACCESS;
            OP_NONE:           state_next = S_IDLE;
          endcase
        end
      end
      S_ALLOC_CHK: begin
        state_next = table_full ? S_IDLE : S_ALLOC_RUN;
      end
      S_ALLOC_RUN: begin
        if (create_more) begin
          mem_we    = 1'b1;
          mem_waddr = blocks_created[BLK_W-1:0];
          mem_wdata = !give_frame;
          if (give_frame) begin
            // New block goes to the front; the chain grows by one cell.
            front = '{valid: 1'b1, blk: blocks_created[BLK_W-1:0],
                      frame: count[FRAME_W-1:0], dirty: 1'b0};
            for (int i = 0; i < FRAMES_MAX; i++) begin
              shift[i] = (COUNT_W'(i) <= count);
            end
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ACCESS: begin
        state_next = S_IDLE;
        if (!unalloc) begin
          if (hit_any) begin
            // Cells up to the matched one move down by one place.
            front       = hit_entry;
            front.dirty = hit_entry.dirty | is_write;
            for (int i = 0; i < FRAMES_MAX; i++) begin
              for (int j = 0; j < FRAMES_MAX; j++) begin
                if (j >= i && match[j]) begin
                  shift[i] = 1'b1;
                end
              end
            end
          end else if (count != '0) begin
            // The last cell is evicted and its frame handed to the new block.
            front = '{valid: 1'b1, blk: idx_r, frame: victim.frame,
                      dirty: fresh_q | is_write};
            for (int i = 0; i < FRAMES_MAX; i++) begin
              shift[i] = (COUNT_W'(i) < count);
            end
            mem_we    = 1'b1;
            mem_waddr = idx_r;
            mem_wdata = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fresh_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      fresh_q <= fresh_mem[block_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      bytes_used     <= '0;
      blocks_created <= '0;
      count          <= '0;
      log2_reg       <= 5'd12;
      max_res_reg    <= 4'd8;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_BLOCK_LOG2: log2_reg    <= cfg_data;
          REG_MAX_RES:    max_res_reg <= cfg_data[3:0];
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r  <= opcode_t'(opcode);
            cnt_r <= byte_count;
            idx_r <= block_index;
            if (opcode_t'(opcode) == OP_NONE) begin
              done            <= 1'b1;
              alloc_offset    <= '0;
              frame           <= '0;
              hit             <= 1'b0;
              writeback_valid <= 1'b0;
              writeback_block <= '0;
              fill_action     <= FILL_NONE;
              status          <= STAT_OK;
            end
          end
        end
        S_ALLOC_CHK: begin
          alloc_offset    <= bytes_used[25:0];
          frame           <= '0;
          hit             <= 1'b0;
          writeback_valid <= 1'b0;
          writeback_block <= '0;
          fill_action     <= FILL_NONE;
          if (table_full) begin
            done   <= 1'b1;
            status <= STAT_FULL;
          end else begin
            status     <= STAT_OK;
            bytes_used <= newused[26:0];
            endblk_r   <= endblk_w[BLK_W-1:0];
          end
        end
        S_ALLOC_RUN: begin
          if (create_more) begin
            blocks_created <= blocks_created + (BLK_W+1)'(1);
            if (give_frame) begin
              count <= count + COUNT_W'(1);
            end
          end else begin
            done <= 1'b1;
          end
        end
        S_ACCESS: begin
          done            <= 1'b1;
          alloc_offset    <= '0;
          frame           <= '0;
          hit             <= 1'b0;
          writeback_valid <= 1'b0;
          writeback_block <= '0;
          fill_action     <= FILL_NONE;
          status          <= STAT_OK;
          if (unalloc || (!hit_any && count == '0)) begin
            status <= STAT_UNALLOC;
          end else if (hit_any) begin
            frame <= hit_entry.frame;
            hit   <= 1'b1;
          end else begin
            frame           <= victim.frame;
            writeback_valid <= victim.dirty;
            writeback_block <= victim.dirty ? victim.blk : '0;
            fill_action     <= fresh_q ? FILL_ZERO : FILL_LOAD;
          end
        end
      endcase
    end
  end

  // A block may sit in at most one cell of the chain.
  a_match_unique: assert property (@(posedge clk) disable iff (rst) $onehot0(match))
    else $error("block found in more than one recency cell");

  // The chain never holds more entries than there are frames.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(FRAMES_MAX))
    else $error("recency count beyond the frame pool");

  // A result is only given once the controller is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a transaction is still running");

  // A hit never asks for a fill or a write-back.
  a_hit_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (fill_action == FILL_NONE && !writeback_valid))
    else $error("hit reported together with fill or write-back");

endmodule

/* test/tb_lru_block_cache_manager_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_block_cache_manager_unit: self-checking bench for the LRU frame manager
// Drives alloc, access and unused-opcode transactions with random gaps,
// predicts each result with a behavioural model of the heap and recency list,
// and compares every result field by field in order.
// ----------------------------------------------------------------------------
module tb_lru_block_cache_manager_unit;
  import lbc_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           opcode;
  logic [19:0]          byte_count;
  logic [BLK_W-1:0]     block_index;
  logic                 cfg_wr_en;
  logic                 cfg_index;
  logic [4:0]           cfg_data;
  logic                 done;
  logic [25:0]          alloc_offset;
  logic [FRAME_W-1:0]   frame;
  logic                 hit;
  logic                 writeback_valid;
  logic [BLK_W-1:0]     writeback_block;
  logic [1:0]           fill_action;
  logic [1:0]           status;

  typedef struct packed {
    logic [1:0]  op;
    logic [19:0] cnt;
    logic [9:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic [25:0] offset;
    logic [2:0]  frm;
    logic        hit;
    logic        wb_valid;
    logic [9:0]  wb_block;
    logic [1:0]  fill;
    logic [1:0]  stat;
  } outcome_t;

  lru_block_cache_manager_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .byte_count(byte_count), .block_index(block_index), .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .alloc_offset(alloc_offset), .frame(frame), .hit(hit),
    .writeback_valid(writeback_valid), .writeback_block(writeback_block),
    .fill_action(fill_action), .status(status)
  );

  // Shadow copy of the block's state, kept by the predictor.
  logic [4:0]  shadow_log2;
  logic [3:0]  shadow_maxres;
  logic [26:0] heap_used;
  int unsigned blocks_made;
  logic        res_flag [BLOCKS_MAX];
  logic [2:0]  frame_of [BLOCKS_MAX];
  logic        dirty_flag [BLOCKS_MAX];
  logic        fresh_flag [BLOCKS_MAX];
  int unsigned lru_list [$];   // entry 0 is the most recently used block

  cmd_t        pending_cmds [$];
  outcome_t    expected_outcomes [$];
  int          failures;

  // Works out the result of one transaction and advances the shadow state.
  function automatic outcome_t predict_outcome(cmd_t c);
    outcome_t    r;
    int unsigned lg, mx, newused, endblk, b, victim;
    r = '0;
    lg = (shadow_log2 < 4) ? 4 : (shadow_log2 > 16) ? 16 : shadow_log2;
    mx = (shadow_maxres == 0) ? 1 : (shadow_maxres > FRAMES_MAX) ? FRAMES_MAX : shadow_maxres;
    if (c.op == OP_ALLOC) begin
      newused = heap_used + c.cnt;
      r.offset = heap_used[25:0];
      if (newused > 27'h7FFFFFF) begin
        r.stat = STAT_FULL;
        return r;
      end
      endblk = newused >> lg;
      if (endblk >= BLOCKS_MAX) begin
        r.stat = STAT_FULL;
        return r;
      end
      heap_used = newused[26:0];
      while (blocks_made <= endblk) begin
        b = blocks_made;
        dirty_flag[b] = 1'b0;
        if (b < mx && lru_list.size() < FRAMES_MAX) begin
          frame_of[b] = 3'(lru_list.size());
          res_flag[b] = 1'b1;
          fresh_flag[b] = 1'b0;
          lru_list.push_front(b);
        end else begin
          frame_of[b] = 0;
          res_flag[b] = 1'b0;
          fresh_flag[b] = 1'b1;
        end
        blocks_made++;
      end
      return r;
    end
    if (c.op == OP_NONE) return r;
    if (c.idx >= blocks_made) begin
      r.stat = STAT_UNALLOC;
      return r;
    end
    if (res_flag[c.idx]) begin
      foreach (lru_list[i]) begin
        if (lru_list[i] == c.idx) begin
          lru_list.delete(i);
          break;
        end
      end
      lru_list.push_front(c.idx);
      r.hit = 1'b1;
    end else begin
      if (lru_list.size() == 0) begin
        r.stat = STAT_UNALLOC;
        return r;
      end
      victim = lru_list.pop_back();
      if (dirty_flag[victim]) begin
        r.wb_valid = 1'b1;
        r.wb_block = victim[9:0];
        dirty_flag[victim] = 1'b0;
      end
      res_flag[victim] = 1'b0;
      frame_of[c.idx] = frame_of[victim];
      res_flag[c.idx] = 1'b1;
      if (fresh_flag[c.idx]) begin
        fresh_flag[c.idx] = 1'b0;
        dirty_flag[c.idx] = 1'b1;
        r.fill = FILL_ZERO;
      end else begin
        dirty_flag[c.idx] = 1'b0;
        r.fill = FILL_LOAD;
      end
      lru_list.push_front(c.idx);
    end
    if (c.op == OP_WRITE) dirty_flag[c.idx] = 1'b1;
    r.frm = frame_of[c.idx];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Acceptance as seen at the last rising edge.
  logic busy_at_edge;

  // Driver: presents queued transactions at the falling edge with random gaps.
  // A transaction is accepted at the rising edge with start high and busy low,
  // so start is only lowered once that edge has passed.
  int gap_left;
  bit driver_hold;   // set by the stimulus block to stop the driver
  initial begin
    start = 1'b0; opcode = '0; byte_count = '0; block_index = '0;
    gap_left = 0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_at_edge) begin
        // Accepted at the last rising edge.
        start <= 1'b0;
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
                    ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_cmds.size() > 0 && !driver_hold) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          opcode <= c.op; byte_count <= c.cnt; block_index <= c.idx;
          start <= 1'b1;
        end
      end
    end
  end

  // Acceptance sampled at the rising edge; prediction happens there too.
  initial begin
    busy_at_edge = 1'b1;
  end
  always @(posedge clk) begin
    busy_at_edge <= busy;
    if (!rst && start && !busy) begin
      cmd_t c;
      c.op = opcode; c.cnt = byte_count; c.idx = block_index;
      expected_outcomes.push_back(predict_outcome(c));
    end
  end

  // Monitor: each strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      outcome_t got, want;
      got = {alloc_offset, frame, hit, writeback_valid, writeback_block,
             fill_action, status};
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, got);
        failures++;
      end else begin
        want = expected_outcomes.pop_front();
        if (got.offset !== want.offset)
          $display("%0t: alloc_offset exp %0d got %0d", $time, want.offset, got.offset);
        if (got.frm !== want.frm)
          $display("%0t: frame exp %0d got %0d", $time, want.frm, got.frm);
        if (got.hit !== want.hit)
          $display("%0t: hit exp %0d got %0d", $time, want.hit, got.hit);
        if (got.wb_valid !== want.wb_valid)
          $display("%0t: writeback_valid exp %0d got %0d", $time, want.wb_valid,
                   got.wb_valid);
        if (got.wb_block !== want.wb_block)
          $display("%0t: writeback_block exp %0d got %0d", $time, want.wb_block,
                   got.wb_block);
        if (got.fill !== want.fill)
          $display("%0t: fill_action exp %0d got %0d", $time, want.fill, got.fill);
        if (got.stat !== want.stat)
          $display("%0t: status exp %0d got %0d", $time, want.stat, got.stat);
        if (got !== want) failures++;
      end
    end
  end

  // Waits until every queued transaction is accepted and answered, then lets
  // the block settle before a register write.
  task automatic drain_and_settle();
    while (pending_cmds.size() > 0 || start || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Register writes only happen while the block is idle.
  task automatic write_reg(logic idx, logic [4:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_BLOCK_LOG2) shadow_log2 = val;
    else shadow_maxres = val[3:0];
  endtask

  task automatic queue_cmd(logic [1:0] op, logic [19:0] cnt, logic [9:0] idx);
    cmd_t c;
    c.op = op; c.cnt = cnt; c.idx = idx;
    pending_cmds.push_back(c);
  endtask

  // Random phase: small allocations mostly, accesses aimed at created blocks
  // with a sprinkling of out-of-range indices and unused opcodes.
  task automatic random_phase(int n);
    int unsigned k, sel, made;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      made = (blocks_made_hint() == 0) ? 1 : blocks_made_hint();
      if (sel < 12)
        queue_cmd(OP_ALLOC, ($urandom_range(0, 19) == 0) ? 20'($urandom) :
                  20'($urandom_range(0, 300)), '0);
      else if (sel < 55)
        queue_cmd(OP_READ, 20'($urandom), 10'($urandom_range(0, made + 1)));
      else if (sel < 95)
        queue_cmd(OP_WRITE, 20'($urandom), 10'($urandom_range(0, made + 1)));
      else if (sel < 98)
        queue_cmd(2'($urandom_range(1, 2)), 20'($urandom), 10'($urandom));
      else
        queue_cmd(OP_NONE, 20'($urandom), 10'($urandom));
    end
  endtask

  // Blocks created so far, capped at 40 and ignoring transactions still in
  // the queue; good enough to aim the random indices near the live range.
  function automatic int unsigned blocks_made_hint();
    return (blocks_made > 40) ? 40 : blocks_made;
  endfunction

  initial begin
    failures = 0;
    driver_hold = 0;
    cfg_wr_en = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    shadow_log2 = 5'd12; shadow_maxres = 4'd8;
    heap_used = '0; blocks_made = 0;
    foreach (res_flag[i]) begin
      res_flag[i] = 0; frame_of[i] = 0; dirty_flag[i] = 0; fresh_flag[i] = 0;
    end
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: default settings, unallocated access, exact-boundary alloc,
    // unused opcode, then the smallest block size with one frame.
    queue_cmd(OP_READ, '0, 10'd0);
    queue_cmd(OP_NONE, 20'hFFFFF, 10'h3FF);
    queue_cmd(OP_ALLOC, 20'd4096, '0);
    queue_cmd(OP_READ, '0, 10'd1);
    queue_cmd(OP_WRITE, '0, 10'd0);
    queue_cmd(OP_ALLOC, 20'hFFFFF, '0);
    queue_cmd(OP_READ, '0, 10'h3FF);
    queue_cmd(OP_ALLOC, 20'hFFFFF, '0);
    drain_and_settle();
    write_reg(REG_BLOCK_LOG2, 5'd0);
    write_reg(REG_MAX_RES, 5'd0);
    queue_cmd(OP_ALLOC, 20'd0, '0);
    queue_cmd(OP_ALLOC, 20'd40, '0);
    queue_cmd(OP_WRITE, '0, 10'd2);
    queue_cmd(OP_READ, '0, 10'd3);
    queue_cmd(OP_READ, '0, 10'd2);
    queue_cmd(OP_WRITE, '0, 10'd1);
    queue_cmd(OP_READ, '0, 10'd0);
    queue_cmd(OP_ALLOC, 20'hFFFFF, '0);   // table full
    drain_and_settle();

    // Random phases across settings; reset of the bench state is not possible,
    // so the heap keeps growing, and large blocks are reserved for later.
    write_reg(REG_BLOCK_LOG2, 5'd4);
    write_reg(REG_MAX_RES, 5'd3);
    random_phase(320);
    drain_and_settle();
    write_reg(REG_BLOCK_LOG2, 5'd31);
    write_reg(REG_MAX_RES, 5'd15);
    random_phase(320);
    // Sender pauses until every expected result has come back.
    repeat (200) @(posedge clk);
    driver_hold = 1;
    drain_hold();
    driver_hold = 0;
    random_phase(320);
    drain_and_settle();
    write_reg(REG_BLOCK_LOG2, 5'd7);
    write_reg(REG_MAX_RES, 5'd1);
    random_phase(320);
    drain_and_settle();
    if (failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  task automatic drain_hold();
    while (start || expected_outcomes.size() > 0) @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/lbc_pkg.sv
rtl/core/lbc_cell.sv
rtl/core/lru_block_cache_manager_unit.sv
test/tb_lru_block_cache_manager_unit.sv
